// ===== src/gea_pkg.sv =====
// ----------------------------------------------------------------------------
// gea_pkg
// Shared types, widths, codes and commands of the gated exponential average.
// ----------------------------------------------------------------------------
package gea_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int FRAC_BITS      = 16;
  localparam int AVG_BITS       = SAMPLE_BITS + FRAC_BITS;
  localparam int TIME_BITS      = 32;
  localparam int DECAY_BITS     = 16;
  localparam int W_BITS         = DECAY_BITS + 1;
  localparam int COUNT_BITS     = 17;
  localparam int DIFF_BITS      = AVG_BITS + 1;
  localparam int SUM_BITS       = DIFF_BITS + 1;
  localparam int PROD_BITS      = DIFF_BITS + W_BITS;
  localparam int DIV_STEPS      = DIFF_BITS;
  localparam int MUL_STEPS      = W_BITS;
  localparam int STEP_BITS      = $clog2(DIFF_BITS);
  localparam int CFG_INDEX_BITS = 8;
  localparam int CFG_DATA_BITS  = 32;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = COUNT_BITS'(65536);

  localparam logic [CFG_INDEX_BITS-1:0] REG_DECAY_FACTOR    = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_WARMUP_SAMPLES  = CFG_INDEX_BITS'(1);
  localparam logic [CFG_INDEX_BITS-1:0] REG_HOLD_AFTER      = CFG_INDEX_BITS'(2);
  localparam logic [CFG_INDEX_BITS-1:0] REG_UPDATE_INTERVAL = CFG_INDEX_BITS'(3);

  typedef struct packed {
    logic [TIME_BITS-1:0]          time_ms;
    logic signed [SAMPLE_BITS-1:0] sample;
  } in_req_t;

  typedef struct packed {
    logic                       accepted;
    logic signed [AVG_BITS-1:0] average;
    logic signed [AVG_BITS-1:0] held_value;
    logic [COUNT_BITS-1:0]      accepted_count;
  } out_rsp_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic div_step;
    logic mul_step;
    logic base;
    logic commit;
    logic out_load;
  } gea_cmd_t;

  typedef struct packed {
    logic take;
    logic mean_mode;
  } gea_status_t;

endpackage

// ===== src/gea_ctrl.sv =====
// ----------------------------------------------------------------------------
// gea_ctrl
// Sequencer: gate check, divide or multiply steps, commit, result handoff.
// ----------------------------------------------------------------------------
module gea_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  gea_pkg::gea_status_t status,
  output gea_pkg::gea_cmd_t    cmd
);
  import gea_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EVAL   = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_BASE   = 3'd3;
  localparam logic [2:0] S_MUL    = 3'd4;
  localparam logic [2:0] S_COMMIT = 3'd5;
  localparam logic [2:0] S_FINISH = 3'd6;

  logic [2:0]           state, state_next;
  logic [STEP_BITS-1:0] cnt, cnt_next;
  logic                 out_valid_next;
  logic                 slot_free;

  assign in_stall  = (state != S_IDLE);
  assign slot_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.prep = 1'b1;
        cnt_next = '0;
        if (!status.take) state_next = S_FINISH;
        else if (status.mean_mode) state_next = S_DIV;
        else state_next = S_MUL;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == STEP_BITS'(DIV_STEPS - 1)) state_next = S_BASE;
      end
      S_BASE: begin
        cmd.base   = 1'b1;
        state_next = S_COMMIT;
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == STEP_BITS'(MUL_STEPS - 1)) state_next = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) out_valid_next = 1'b1;
    else if (out_valid && !out_stall) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== src/gea_datapath.sv =====
// ----------------------------------------------------------------------------
// gea_datapath
// Registers, time gate, radix-2 divider, shift-add multiplier, result register.
// ----------------------------------------------------------------------------
module gea_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  gea_pkg::in_req_t                     in_data,
  output gea_pkg::out_rsp_t                    out_data,
  input  logic                                 cfg_we,
  input  logic [gea_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [gea_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  gea_pkg::gea_cmd_t                    cmd,
  output gea_pkg::gea_status_t                 status
);
  import gea_pkg::*;

  // configuration
  logic [DECAY_BITS-1:0] decay_factor;
  logic [15:0]           warmup_samples;
  logic [15:0]           hold_after;
  logic [TIME_BITS-1:0]  update_interval;

  // block state
  logic signed [AVG_BITS-1:0] running_average;
  logic signed [AVG_BITS-1:0] held_average;
  logic                       held_valid;
  logic [COUNT_BITS-1:0]      sample_count;
  logic [TIME_BITS-1:0]       last_accept_time;

  // work registers
  logic [TIME_BITS-1:0]          in_time;
  logic signed [SAMPLE_BITS-1:0] in_x;
  logic                          take_reg;
  logic                          mean_reg;
  logic signed [DIFF_BITS-1:0]   d_reg;
  logic                          d_neg;
  logic [DIFF_BITS-1:0]          dq;
  logic [COUNT_BITS-1:0]         rem;
  logic [W_BITS-1:0]             wsh;
  logic signed [PROD_BITS-1:0]   acc;
  logic signed [SUM_BITS-1:0]    base_reg;
  logic                          r_neg;
  logic                          r_pos;

  logic [TIME_BITS:0]          gate_limit;
  logic signed [AVG_BITS-1:0]  big_x;
  logic signed [DIFF_BITS-1:0] d_now;
  logic [DIFF_BITS-1:0]        d_mag;
  logic [W_BITS-1:0]           w_now;
  logic [COUNT_BITS-1:0]       m;
  logic [COUNT_BITS:0]         rem_sh;
  logic                        ge;
  logic signed [SUM_BITS-1:0]  q_signed;
  logic signed [SUM_BITS-1:0]  avg_ext;
  logic signed [SUM_BITS-1:0]  mean_val;
  logic signed [SUM_BITS-1:0]  ema_val;
  logic signed [SUM_BITS-1:0]  new_avg;
  logic                        st_pos;
  logic                        st_neg;
  logic [COUNT_BITS-1:0]       count_next;

  assign gate_limit = {1'b0, last_accept_time} + {1'b0, update_interval};
  assign status.take      = ({1'b0, in_time} >= gate_limit);
  assign status.mean_mode = (sample_count < {1'b0, warmup_samples});

  assign big_x = {in_x, {FRAC_BITS{1'b0}}};
  assign d_now = DIFF_BITS'(big_x) - DIFF_BITS'(running_average);
  assign d_mag = d_now[DIFF_BITS-1] ? DIFF_BITS'(-d_now) : DIFF_BITS'(d_now);
  assign w_now = W_BITS'(1 << DECAY_BITS) - {1'b0, decay_factor};

  assign m      = sample_count + 1'b1;
  assign rem_sh = {rem, dq[DIFF_BITS-1]};
  assign ge     = (rem_sh >= {1'b0, m});

  assign avg_ext  = SUM_BITS'(running_average);
  assign q_signed = d_neg ? -SUM_BITS'({1'b0, dq}) : SUM_BITS'({1'b0, dq});

  assign st_pos = (base_reg != '0) ? !base_reg[SUM_BITS-1] : r_pos;
  assign st_neg = (base_reg != '0) ?  base_reg[SUM_BITS-1] : r_neg;

  always_comb begin
    mean_val = base_reg;
    if (st_pos && r_neg) mean_val = base_reg - 1'b1;
    else if (st_neg && r_pos) mean_val = base_reg + 1'b1;
  end

  assign ema_val    = avg_ext + acc[PROD_BITS-1:DECAY_BITS];
  assign new_avg    = mean_reg ? mean_val : ema_val;
  assign count_next = (sample_count < COUNT_MAX) ? sample_count + 1'b1 : sample_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      decay_factor    <= '0;
      warmup_samples  <= '0;
      hold_after      <= '0;
      update_interval <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DECAY_FACTOR:    decay_factor    <= cfg_data[DECAY_BITS-1:0];
        REG_WARMUP_SAMPLES:  warmup_samples  <= cfg_data[15:0];
        REG_HOLD_AFTER:      hold_after      <= cfg_data[15:0];
        REG_UPDATE_INTERVAL: update_interval <= cfg_data[TIME_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_average  <= '0;
      held_average     <= '0;
      held_valid       <= 1'b0;
      sample_count     <= '0;
      last_accept_time <= '0;
    end else if (cmd.commit) begin
      running_average  <= new_avg[AVG_BITS-1:0];
      sample_count     <= count_next;
      last_accept_time <= in_time;
      if (count_next <= {1'b0, hold_after} || !held_valid) begin
        held_average <= new_avg[AVG_BITS-1:0];
        held_valid   <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_time <= in_data.time_ms;
      in_x    <= in_data.sample;
    end
    if (cmd.prep) begin
      take_reg <= status.take;
      mean_reg <= status.mean_mode;
      d_reg    <= d_now;
      d_neg    <= d_now[DIFF_BITS-1];
      dq       <= d_mag;
      rem      <= '0;
      wsh      <= w_now;
      acc      <= '0;
    end
    if (cmd.div_step) begin
      rem <= ge ? COUNT_BITS'(rem_sh - {1'b0, m}) : rem_sh[COUNT_BITS-1:0];
      dq  <= {dq[DIFF_BITS-2:0], ge};
    end
    if (cmd.mul_step) begin
      acc <= (acc <<< 1) + (wsh[W_BITS-1] ? PROD_BITS'(d_reg) : PROD_BITS'(0));
      wsh <= {wsh[W_BITS-2:0], 1'b0};
    end
    if (cmd.base) begin
      base_reg <= avg_ext + q_signed;
      r_neg    <= d_neg && (rem != '0);
      r_pos    <= !d_neg && (rem != '0);
    end
    if (cmd.out_load) begin
      out_data.accepted       <= take_reg;
      out_data.average        <= running_average;
      out_data.held_value     <= held_average;
      out_data.accepted_count <= sample_count;
    end
  end

endmodule

// ===== src/gated_exponential_average_top.sv =====
// ----------------------------------------------------------------------------
// gated_exponential_average_top
// Time-gated running mean / exponential average with a frozen held copy.
// ----------------------------------------------------------------------------
//   channel  handshake             payload
//   in       in_valid / in_stall   in_data   (time_ms, sample)
//   out      out_valid / out_stall out_data  (accepted, average, held_value,
//                                            accepted_count)
//   cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A warm-up sample runs through the 41-step radix-2 divider.
// An exponential sample runs through the 17-step shift-add multiplier.
// A rejected sample skips both. One request is in work at a time.
// The result register lets the next request enter while out_stall holds a result.
// Synchronous reset clears configuration, state and both valid flags.
// ----------------------------------------------------------------------------
module gated_exponential_average_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  gea_pkg::in_req_t                   in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output gea_pkg::out_rsp_t                  out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [gea_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [gea_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import gea_pkg::*;

  gea_cmd_t    cmd;
  gea_status_t status;

  assign cfg_ready = 1'b1;

  gea_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  gea_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while a request is in work");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.accepted_count <= COUNT_MAX)
    else $error("accepted count beyond saturation");

  a_empty_state: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.accepted_count == '0 |->
      out_data.average == '0 && out_data.held_value == '0 && !out_data.accepted)
    else $error("average moved with no sample taken");

endmodule
